### hw/rtl/vbra_pkg.sv
// ----------------------------------------------------------------------------
// vbra_pkg
// Shared constants, codes and control types of the variable block ring
// allocator.
// ----------------------------------------------------------------------------
package vbra_pkg;

    localparam int CAPACITY     = 4096;
    localparam int HEADER_BYTES = 4;
    localparam int DATA_W       = 13;
    localparam int SUM_W        = DATA_W + 1;
    localparam int ADDR_W       = $clog2(CAPACITY);

    localparam logic [DATA_W-1:0] HDR_LEN        = DATA_W'(HEADER_BYTES);
    localparam logic [DATA_W-1:0] CAP_LIMIT      = DATA_W'(CAPACITY);
    localparam logic [DATA_W-1:0] BUF_SIZE_RESET = DATA_W'(4096);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_UNALLOC = 2'd1,
        OP_FREE    = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_BADPTR  = 3'd3,
        ST_ORDER   = 3'd4,
        ST_BADSIZE = 3'd5
    } t_status;

    typedef struct packed {
        logic clear;
        logic load;
        logic exec;
        logic cfg_wr;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
    } t_dp_stat;

endpackage

### hw/rtl/vbra_ctrl.sv
// ----------------------------------------------------------------------------
// vbra_ctrl
// Controller: header clear sweep after reset, request accept, execute step.
// ----------------------------------------------------------------------------
module vbra_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    output vbra_pkg::t_cmd     o_cmd,
    input  vbra_pkg::t_dp_stat i_stat
);
    import vbra_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state != S_EXEC);

    always_comb begin
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.exec   = (r_state == S_EXEC);
        o_cmd.cfg_wr = i_cfg_valid && o_cfg_ready;
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    a_exec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_IDLE))
        else $error("execute lasted more than one cycle");

    a_clear_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && !i_stat.clear_done) |=> (r_state == S_CLEAR))
        else $error("header clear left early");

endmodule

### hw/rtl/vbra_datapath.sv
// ----------------------------------------------------------------------------
// vbra_datapath
// Ring offsets, header memory, alloc / unalloc / free update and result regs.
// ----------------------------------------------------------------------------
module vbra_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vbra_pkg::t_cmd                i_cmd,
    output vbra_pkg::t_dp_stat            o_stat,
    input  logic [1:0]                    i_opcode,
    input  logic [vbra_pkg::DATA_W-1:0]   i_request_size,
    input  logic [vbra_pkg::DATA_W-1:0]   i_block_offset,
    input  logic [vbra_pkg::DATA_W-1:0]   i_cfg_data,
    output logic                          o_strobe,
    output logic [2:0]                    o_status,
    output logic [vbra_pkg::DATA_W-1:0]   o_payload_offset,
    output logic [vbra_pkg::DATA_W-1:0]   o_largest_free
);
    import vbra_pkg::*;

    logic [DATA_W-1:0] r_bs, r_rd, r_wr;
    logic              r_full;
    logic [1:0]        r_op;
    logic [DATA_W-1:0] r_req, r_boff, r_mem_q;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_strobe;
    t_status           r_status;
    logic [DATA_W-1:0] r_payload;
    logic [DATA_W-1:0] r_hdr_mem [CAPACITY];

    logic [DATA_W-1:0] n_rd, n_wr, n_bs;
    logic              n_full;
    t_status           st;
    logic [DATA_W-1:0] payload;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa, rd_addr;
    logic [SUM_W-1:0]  total, len_end, tail_end, wrap_end;
    logic [DATA_W-1:0] hdr, tail_room, wrap_start, wrap_room;
    logic [DATA_W-1:0] unalloc_limit, free_limit;
    logic              bad_ptr;
    logic [DATA_W-1:0] run_a, run_b;

    assign rd_addr = ADDR_W'(i_block_offset - HDR_LEN);
    assign n_bs    = (i_cfg_data > CAP_LIMIT) ? CAP_LIMIT : i_cfg_data;

    always_comb begin
        total         = {1'b0, r_req} + SUM_W'(HEADER_BYTES);
        hdr           = r_boff - HDR_LEN;
        len_end       = {1'b0, hdr} + {1'b0, r_mem_q};
        tail_room     = r_bs - r_wr;
        tail_end      = {1'b0, r_wr} + total;
        wrap_start    = (r_wr <= r_rd) ? r_wr : '0;
        wrap_room     = r_rd - wrap_start;
        wrap_end      = {1'b0, wrap_start} + total;
        bad_ptr       = (r_boff < HDR_LEN) || (hdr >= r_bs);
        unalloc_limit = (r_wr == '0) ? r_bs : r_wr;
        free_limit    = (r_wr > r_rd) ? r_wr : r_bs;

        n_rd    = r_rd;
        n_wr    = r_wr;
        n_full  = r_full;
        st      = ST_BADPTR;
        payload = '0;
        mem_we  = 1'b0;
        mem_wa  = r_wr[ADDR_W-1:0];

        unique case (r_op)
            OP_ALLOC: begin
                if (r_full) begin
                    st = ST_FULL;
                end else if (r_wr >= r_rd && {1'b0, tail_room} >= total) begin
                    st      = ST_OK;
                    mem_we  = 1'b1;
                    mem_wa  = r_wr[ADDR_W-1:0];
                    payload = r_wr + HDR_LEN;
                    n_wr    = (tail_end == {1'b0, r_bs}) ? '0 : tail_end[DATA_W-1:0];
                    n_full  = (n_wr == r_rd);
                end else if ({1'b0, wrap_room} >= total) begin
                    st      = ST_OK;
                    mem_we  = 1'b1;
                    mem_wa  = wrap_start[ADDR_W-1:0];
                    payload = wrap_start + HDR_LEN;
                    n_wr    = wrap_end[DATA_W-1:0];
                    n_full  = (wrap_end == {1'b0, r_rd});
                end else begin
                    st = ST_NOSPACE;
                end
            end
            OP_UNALLOC: begin
                if (bad_ptr || len_end != {1'b0, unalloc_limit}) begin
                    st = ST_BADPTR;
                end else begin
                    st     = ST_OK;
                    n_wr   = hdr;
                    n_full = 1'b0;
                end
            end
            OP_FREE: begin
                if (bad_ptr) begin
                    st = ST_BADPTR;
                end else if (hdr != r_rd && hdr != '0) begin
                    st = ST_ORDER;
                end else if (len_end > {1'b0, free_limit}) begin
                    st = ST_BADSIZE;
                end else begin
                    st     = ST_OK;
                    n_rd   = (len_end == {1'b0, r_bs}) ? '0 : len_end[DATA_W-1:0];
                    n_full = 1'b0;
                    if (n_rd == r_wr) begin
                        n_rd = '0;
                        n_wr = '0;
                    end
                end
            end
            default: begin
                st = ST_BADPTR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs       <= BUF_SIZE_RESET;
            r_rd       <= '0;
            r_wr       <= '0;
            r_full     <= 1'b0;
            r_strobe   <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            r_strobe <= i_cmd.exec;
            if (i_cmd.cfg_wr) begin
                r_bs   <= n_bs;
                r_rd   <= '0;
                r_wr   <= '0;
                r_full <= 1'b0;
            end else if (i_cmd.exec) begin
                r_rd   <= n_rd;
                r_wr   <= n_wr;
                r_full <= n_full;
            end
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_req  <= i_request_size;
            r_boff <= i_block_offset;
        end
        if (i_cmd.exec) begin
            r_status  <= st;
            r_payload <= payload;
        end
    end

    // header memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_hdr_mem[r_clr_addr] <= '0;
        end else if (i_cmd.exec && mem_we) begin
            r_hdr_mem[mem_wa] <= total[DATA_W-1:0];
        end
        if (i_cmd.load) r_mem_q <= r_hdr_mem[rd_addr];
    end

    always_comb begin
        if (r_wr >= r_rd) begin
            run_a = r_bs - r_wr;
            run_b = r_rd;
        end else begin
            run_a = r_rd - r_wr;
            run_b = run_a;
        end
    end

    assign o_largest_free    = r_full ? '0 : ((run_a < run_b) ? run_b : run_a);
    assign o_strobe          = r_strobe;
    assign o_status          = r_status;
    assign o_payload_offset  = r_payload;
    assign o_stat.clear_done = (r_clr_addr == '1);

    a_full_offsets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_rd == r_wr))
        else $error("full flag set with differing offsets");

    a_wr_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr < r_bs) || (r_wr == '0))
        else $error("write offset outside ring");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe longer than one cycle");

endmodule

### hw/rtl/variable_block_ring_allocator.sv
// ----------------------------------------------------------------------------
// variable_block_ring_allocator
// Ring allocator for variable-length blocks with per-block length headers.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and its result is
// on the result ports for one cycle with o_strobe high, registered from the
// execute step that follows the request; the receiver cannot stall it, so it
// must sample o_strobe every cycle. Each request runs as one header memory
// read, then one update step; a new request is taken only once busy is low
// again. After reset the header memory is cleared one entry a cycle, all 4096
// entries, while busy stays high; buffer size writes are taken at any time
// except in the update step, and reset both offsets and the full flag.
module variable_block_ring_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_opcode,
    input  logic [vbra_pkg::DATA_W-1:0] i_request_size,
    input  logic [vbra_pkg::DATA_W-1:0] i_block_offset,
    output logic                        o_strobe,
    output logic [2:0]                  o_status,
    output logic [vbra_pkg::DATA_W-1:0] o_payload_offset,
    output logic [vbra_pkg::DATA_W-1:0] o_largest_free,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [vbra_pkg::DATA_W-1:0] i_cfg_data
);
    import vbra_pkg::*;

    t_cmd     cmd;
    t_dp_stat dp_stat;

    vbra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd),
        .i_stat      (dp_stat)
    );

    vbra_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (dp_stat),
        .i_opcode         (i_opcode),
        .i_request_size   (i_request_size),
        .i_block_offset   (i_block_offset),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_payload_offset (o_payload_offset),
        .o_largest_free   (o_largest_free)
    );

endmodule
